[rtl/dlcd_pkg.sv]
`timescale 1ns / 1ps

package dlcd_pkg;

    localparam int READ_W  = 16;
    localparam int VAL_W   = 14;
    localparam int DIG_W   = 4;
    localparam int SEG_W   = 24;

    localparam logic [READ_W-1:0] OVERLOAD_LIMIT = 16'd10000;
    localparam logic [READ_W-1:0] LIMIT_1000     = 16'd1000;
    localparam logic [READ_W-1:0] LIMIT_100      = 16'd100;
    localparam logic [READ_W-1:0] LIMIT_10       = 16'd10;

    // reciprocal multipliers for divide by ten
    localparam logic [15:0] RECIP_10_WIDE   = 16'd52429;  // shift 19, exact below 43699
    localparam logic [7:0]  RECIP_10_NARROW = 8'd205;     // shift 11, exact below 1029

    localparam logic [DIG_W-1:0] NO_DIGIT = 4'd10;

    localparam logic [1:0] POS_LEFT  = 2'd0;
    localparam logic [1:0] POS_MID   = 2'd1;
    localparam logic [1:0] POS_RIGHT = 2'd2;

    // segment words are {byte2, byte1, byte0}
    localparam logic [SEG_W-1:0] POINT_SEG    = 24'h000020;
    localparam logic [SEG_W-1:0] OVERLOAD_SEG = 24'hE18258;

    // format flags carried along the digit pipeline
    typedef struct packed {
        logic overload;
        logic whole;
        logic three_digit;
        logic ge1000;
        logic ge100;
        logic ge10;
    } dlcd_side_t;

    typedef struct packed {
        dlcd_side_t       side;
        logic [DIG_W-1:0] th;
        logic [DIG_W-1:0] hu;
        logic [DIG_W-1:0] te;
        logic [DIG_W-1:0] on;
    } dlcd_digits_t;

    function automatic logic [SEG_W-1:0] seg_lookup(input logic [1:0] pos,
                                                    input logic [DIG_W-1:0] dig);
        logic [SEG_W-1:0] s;
        s = '0;
        case (pos)
            POS_LEFT: begin
                case (dig)
                    4'd0: s = 24'hE10048;
                    4'd1: s = 24'h210000;
                    4'd2: s = 24'hC10044;
                    4'd3: s = 24'h610044;
                    4'd4: s = 24'h21000C;
                    4'd5: s = 24'h60004C;
                    4'd6: s = 24'hE0004C;
                    4'd7: s = 24'h210040;
                    4'd8: s = 24'hE1004C;
                    4'd9: s = 24'h61004C;
                    default: s = '0;
                endcase
            end
            POS_MID: begin
                case (dig)
                    4'd0: s = 24'h028690;
                    4'd1: s = 24'h020080;
                    4'd2: s = 24'h028C10;
                    4'd3: s = 24'h028C80;
                    4'd4: s = 24'h020A80;
                    4'd5: s = 24'h008E80;
                    4'd6: s = 24'h008E90;
                    4'd7: s = 24'h020480;
                    4'd8: s = 24'h028E90;
                    4'd9: s = 24'h028E80;
                    default: s = '0;
                endcase
            end
            POS_RIGHT: begin
                case (dig)
                    4'd0: s = 24'h1C3001;
                    4'd1: s = 24'h100001;
                    4'd2: s = 24'h183100;
                    4'd3: s = 24'h182101;
                    4'd4: s = 24'h140101;
                    4'd5: s = 24'h0C2101;
                    4'd6: s = 24'h0C3101;
                    4'd7: s = 24'h180001;
                    4'd8: s = 24'h1C3101;
                    4'd9: s = 24'h1C2101;
                    default: s = '0;
                endcase
            end
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

[rtl/dlcd_digits.sv]
`timescale 1ns / 1ps

module dlcd_digits
    import dlcd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [READ_W-1:0]   in_reading,
    input  logic                in_whole,
    input  logic                in_three_digit,
    output logic                out_valid,
    input  logic                out_ready,
    output dlcd_digits_t        out_digits
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // stage 1: reading times reciprocal of ten
    logic [VAL_W-1:0] r1_reg;
    logic [29:0]      prod1_reg;
    dlcd_side_t       side1_reg;

    // stage 2: first quotient and ones digit
    logic [10:0]      q1_reg;
    logic [DIG_W-1:0] on2_reg;
    dlcd_side_t       side2_reg;

    // stage 3: second quotient and tens digit
    logic [7:0]       q2_reg;
    logic [DIG_W-1:0] on3_reg, te3_reg;
    dlcd_side_t       side3_reg;

    // stage 4: thousands and hundreds
    dlcd_digits_t     dig4_reg;

    logic [29:0]      prod1_next;
    dlcd_side_t       side1_next;
    logic [10:0]      q1_next;
    logic [VAL_W-1:0] q1x10;
    logic [VAL_W-1:0] on_diff;
    logic [18:0]      prod2;
    logic [10:0]      q2x10;
    logic [10:0]      te_diff;
    logic [15:0]      prod3;
    logic [4:0]       th_next;
    logic [7:0]       thx10;
    logic [7:0]       hu_diff;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        prod1_next             = 30'({16'd0, in_reading[VAL_W-1:0]} * 30'(RECIP_10_WIDE));
        side1_next.overload    = in_reading >= OVERLOAD_LIMIT;
        side1_next.whole       = in_whole;
        side1_next.three_digit = in_three_digit;
        side1_next.ge1000      = in_reading >= LIMIT_1000;
        side1_next.ge100       = in_reading >= LIMIT_100;
        side1_next.ge10        = in_reading >= LIMIT_10;

        q1_next  = prod1_reg[29:19];
        q1x10    = {q1_next, 3'b000} + {2'b00, q1_next, 1'b0};
        on_diff  = r1_reg - q1x10;

        prod2    = 19'({8'd0, q1_reg} * 19'(RECIP_10_NARROW));
        q2x10    = {prod2[18:11], 3'b000} + {2'b00, prod2[18:11], 1'b0};
        te_diff  = q1_reg - q2x10;

        prod3    = 16'({8'd0, q2_reg} * 16'(RECIP_10_NARROW));
        th_next  = prod3[15:11];
        thx10    = 8'({th_next, 3'b000} + {2'b00, th_next, 1'b0});
        hu_diff  = q2_reg - thx10;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            r1_reg    <= in_reading[VAL_W-1:0];
            prod1_reg <= prod1_next;
            side1_reg <= side1_next;
        end
        if (en2) begin
            q1_reg    <= q1_next;
            on2_reg   <= on_diff[DIG_W-1:0];
            side2_reg <= side1_reg;
        end
        if (en3) begin
            q2_reg    <= prod2[18:11];
            te3_reg   <= te_diff[DIG_W-1:0];
            on3_reg   <= on2_reg;
            side3_reg <= side2_reg;
        end
        if (en4) begin
            dig4_reg.side <= side3_reg;
            dig4_reg.th   <= th_next[DIG_W-1:0];
            dig4_reg.hu   <= hu_diff[DIG_W-1:0];
            dig4_reg.te   <= te3_reg;
            dig4_reg.on   <= on3_reg;
        end
    end

    assign out_valid  = v4_reg;
    assign out_digits = dig4_reg;

endmodule

[rtl/dlcd_encode.sv]
`timescale 1ns / 1ps

module dlcd_encode
    import dlcd_pkg::*;
(
    input  dlcd_digits_t       digits,
    output logic [SEG_W-1:0]   seg
);

    logic [DIG_W-1:0] d0, d1, d2;
    logic             point;

    // pick the three shown positions and the point
    always_comb begin
        d0    = digits.th;
        d1    = digits.hu;
        d2    = digits.te;
        point = 1'b1;
        if (digits.side.whole || digits.side.ge1000) begin
            point = 1'b1;
        end else if (digits.side.ge100) begin
            if (digits.side.three_digit) begin
                d0    = digits.hu;
                d1    = digits.te;
                d2    = digits.on;
                point = 1'b0;
            end
        end else if (digits.side.ge10) begin
            d0    = NO_DIGIT;
            d1    = digits.te;
            d2    = digits.on;
            point = 1'b0;
        end else begin
            // single digit, zero included
            d0    = NO_DIGIT;
            d1    = NO_DIGIT;
            d2    = digits.on;
            point = 1'b0;
        end
    end

    always_comb begin
        if (digits.side.overload) begin
            seg = OVERLOAD_SEG;
        end else begin
            seg = seg_lookup(POS_LEFT, d0) | seg_lookup(POS_MID, d1)
                | seg_lookup(POS_RIGHT, d2) | (point ? POINT_SEG : '0);
        end
    end

endmodule

[rtl/decimal_to_lcd_segments.sv]
`timescale 1ns / 1ps

// reading to static three-digit lcd segment encoder
//
// s_ channel: one transfer carries a reading in thousandths (s_tdata) and the
// whole-units flag (s_tuser). m_ channel: one transfer per input carries the
// three segment bytes for the lcd data registers, byte0 in the low bits.
// cfg_we/cfg_wdata write the three-digit milli flag; write it only while no
// transfer is in flight.
//
// pipeline: five register stages, the last of them the output register.
// throughput: one transfer per cycle while m_tready stays high;
// the three divide-by-ten steps (reciprocal multiplies) each take a stage.
//
// reset (aresetn low, synchronous) empties the pipeline and clears the
// config flag. when m_tready is low the output register holds its result and
// the stages behind it fill up; s_tready drops once every stage is full,
// so nothing is lost or repeated.
module decimal_to_lcd_segments
    import dlcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [0:0]  cfg_wdata,      // three_digit_milli

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // reading[15:0]
    input  logic [0:0]  s_tuser,        // whole_units

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata         // seg_byte0[7:0], seg_byte1[15:8], seg_byte2[23:16]
);

    // config flag, sampled with each reading at entry
    logic three_digit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            three_digit_reg <= 1'b0;
        end else if (cfg_we) begin
            three_digit_reg <= cfg_wdata[0];
        end
    end

    // digit split pipeline
    logic         dig_valid;
    logic         dig_ready;
    dlcd_digits_t dig;

    dlcd_digits u_digits (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_reading     (s_tdata),
        .in_whole       (s_tuser[0]),
        .in_three_digit (three_digit_reg),
        .out_valid      (dig_valid),
        .out_ready      (dig_ready),
        .out_digits     (dig)
    );

    // format selection and segment tables
    logic [SEG_W-1:0] seg_next;

    dlcd_encode u_encode (
        .digits (dig),
        .seg    (seg_next)
    );

    // output register, loads when empty or when its result is taken
    logic             m_valid_reg;
    logic [SEG_W-1:0] m_data_reg;

    assign dig_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (dig_ready) begin
            m_valid_reg <= dig_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (dig_ready && dig_valid) begin
            m_data_reg <= seg_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
